[hdl/dcc_pkg.sv]
// Package for the datagram confirm header checker.
// Holds widths, protocol constants, verdict codes and the queue entry types.
// No dependencies.
package dcc_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1024;
  localparam int unsigned HDR_BYTES        = 15;
  localparam int unsigned CAPACITY         = MAX_PACKET_BYTES + HDR_BYTES;
  localparam int unsigned POS_W            = $clog2(CAPACITY + 1);

  localparam int unsigned PORT_W   = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned TERM_W   = BYTE_W + WEIGHT_W;
  localparam int unsigned ACC_W    = 26;
  localparam int unsigned NUM_W    = 25;
  localparam int unsigned SENT_W   = 20;

  localparam int unsigned NUM_MOD     = 1000000;
  localparam int unsigned DIGIT_BIAS  = 5333328;
  localparam int unsigned MIN_LEN     = 6;
  localparam int unsigned DELIVER_LEN = HDR_BYTES + 1;

  localparam int unsigned TYPE_POS    = 6;
  localparam int unsigned DIGIT_FIRST = 8;
  localparam int unsigned DIGIT_LAST  = 13;

  localparam int unsigned RECIP_SHIFT = 45;
  localparam int unsigned RECIP_W     = 26;
  localparam longint unsigned RECIP   = ((64'd1 << RECIP_SHIFT) / NUM_MOD) + 1;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;
  localparam int unsigned QUOT_W      = 5;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CHAR_P = 8'h50;
  localparam logic [BYTE_W-1:0] CHAR_S = 8'h53;
  localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_R = 8'h52;

  localparam logic [2:0] VERDICT_BAD       = 3'd0;
  localparam logic [2:0] VERDICT_WRONGPORT = 3'd1;
  localparam logic [2:0] VERDICT_NORMAL    = 3'd2;
  localparam logic [2:0] VERDICT_SEARCH    = 3'd3;
  localparam logic [2:0] VERDICT_NEW       = 3'd4;
  localparam logic [2:0] VERDICT_REPEAT    = 3'd5;
  localparam logic [2:0] VERDICT_OLD       = 3'd6;
  localparam logic [2:0] VERDICT_REPLY     = 3'd7;

  typedef enum logic [2:0] {
    PKT_OTHER,
    PKT_P,
    PKT_S,
    PKT_C,
    PKT_R
  } pkt_type_e;

  typedef struct packed {
    logic             is_send;
    logic             port_ok;
    logic             bad;
    logic             long_pkt;
    pkt_type_e        ptype;
    logic [ACC_W-1:0] acc;
  } entry_t;

  typedef struct packed {
    logic [2:0]        verdict;
    logic              deliver;
    logic              send_ack;
    logic              waiting;
    logic [SENT_W-1:0] sent_number;
    logic              is_send;
  } res_t;

  function automatic logic [BYTE_W-1:0] magic_byte(input logic [2:0] idx);
    logic [BYTE_W-1:0] val;
    unique case (idx)
      3'd0:    val = 8'h57;
      3'd1:    val = 8'h69;
      3'd2:    val = 8'h64;
      3'd3:    val = 8'h61;
      3'd4:    val = 8'h70;
      3'd5:    val = 8'h5F;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [WEIGHT_W-1:0] digit_weight(input logic [2:0] idx);
    logic [WEIGHT_W-1:0] val;
    unique case (idx)
      3'd0:    val = 17'd100000;
      3'd1:    val = 17'd10000;
      3'd2:    val = 17'd1000;
      3'd3:    val = 17'd100;
      3'd4:    val = 17'd10;
      3'd5:    val = 17'd1;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

endpackage

[hdl/dcc_in_if.sv]
// Input channel of the checker: valid/ready handshake with one packet byte or send event.
// Depends on dcc_pkg.
interface dcc_in_if;
  import dcc_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] byte_value;
  logic              last_byte;
  logic [PORT_W-1:0] source_port;

  modport source (output valid, op, byte_value, last_byte, source_port, input ready);
  modport sink (input valid, op, byte_value, last_byte, source_port, output ready);
endinterface

[hdl/dcc_out_if.sv]
// Output channel of the checker: valid/ready handshake with one verdict item.
// Depends on dcc_pkg.
interface dcc_out_if;
  import dcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        verdict;
  logic              deliver_payload;
  logic              send_ack;
  logic [SENT_W-1:0] ack_number;
  logic              waiting_confirm;
  logic [SENT_W-1:0] sent_number;
  logic              is_send_result;

  modport source (output valid, verdict, deliver_payload, send_ack, ack_number,
                  waiting_confirm, sent_number, is_send_result, input ready);
  modport sink (input valid, verdict, deliver_payload, send_ack, ack_number,
                waiting_confirm, sent_number, is_send_result, output ready);
endinterface

[hdl/dcc_front.sv]
// Front end: takes bytes, tracks the per-packet header state and the partner port,
// and pushes one classified entry per last byte or send event. Depends on dcc_pkg, dcc_in_if.
module dcc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dcc_pkg::PORT_W-1:0]  cfg_wdata_i,
  dcc_in_if.sink                      in_i,
  input  logic                        full_i,
  output logic                        push_o,
  output dcc_pkg::entry_t             entry_o
);
  import dcc_pkg::*;

  logic [PORT_W-1:0] partner_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              mis_q, mis_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [BYTE_W-1:0] fin_q, fin_d;

  logic              accept;
  logic              stored;
  logic              digit_pos;
  logic [TERM_W-1:0] digit_term;
  pkt_type_e         ptype;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign stored     = pos_q < POS_W'(CAPACITY);
  assign digit_pos  = (pos_q >= POS_W'(DIGIT_FIRST)) && (pos_q <= POS_W'(DIGIT_LAST));
  assign digit_term = in_i.byte_value * digit_weight(3'(pos_q - POS_W'(DIGIT_FIRST)));

  always_comb begin
    pos_d  = pos_q;
    mis_d  = mis_q;
    type_d = type_q;
    acc_d  = acc_q;
    fin_d  = fin_q;
    if (stored) begin
      pos_d = POS_W'(pos_q + 1'b1);
      fin_d = in_i.byte_value;
      if (pos_q < POS_W'(MIN_LEN) && in_i.byte_value != magic_byte(pos_q[2:0])) begin
        mis_d = 1'b1;
      end
      if (pos_q == POS_W'(TYPE_POS)) begin
        type_d = in_i.byte_value;
      end
      if (digit_pos) begin
        acc_d = acc_q + ACC_W'(digit_term);
      end
    end
  end

  always_comb begin
    unique case (type_d)
      CHAR_P:  ptype = PKT_P;
      CHAR_S:  ptype = PKT_S;
      CHAR_C:  ptype = PKT_C;
      CHAR_R:  ptype = PKT_R;
      default: ptype = PKT_OTHER;
    endcase
  end

  assign push_o           = accept && (in_i.op || in_i.last_byte);
  assign entry_o.is_send  = in_i.op;
  assign entry_o.port_ok  = in_i.source_port == partner_q;
  assign entry_o.bad      = (fin_d != '0) || mis_d || (pos_d < POS_W'(MIN_LEN));
  assign entry_o.long_pkt = pos_d > POS_W'(DELIVER_LEN);
  assign entry_o.ptype    = ptype;
  assign entry_o.acc      = acc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partner_q <= '0;
      pos_q     <= '0;
      mis_q     <= 1'b0;
      type_q    <= '0;
      acc_q     <= '0;
      fin_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        partner_q <= cfg_wdata_i;
      end
      if (accept && !in_i.op) begin
        if (in_i.last_byte) begin
          pos_q  <= '0;
          mis_q  <= 1'b0;
          type_q <= '0;
          acc_q  <= '0;
          fin_q  <= '0;
        end else begin
          pos_q  <= pos_d;
          mis_q  <= mis_d;
          type_q <= type_d;
          acc_q  <= acc_d;
          fin_q  <= fin_d;
        end
      end
    end
  end

endmodule

[hdl/dcc_fifo.sv]
// Short register queue of classified entries between the front and back ends.
// Depends on dcc_pkg.
module dcc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dcc_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output dcc_pkg::entry_t head_o
);
  import dcc_pkg::*;

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= QCNT_W'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= QCNT_W'(cnt_q - 1'b1);
      end
    end
  end

endmodule

[hdl/dcc_back.sv]
// Back end: decides verdicts, keeps the confirm and send counters, reduces the
// acknowledgement number modulo one million and drives the output. Depends on dcc_pkg, dcc_out_if.
module dcc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  dcc_pkg::entry_t head_i,
  output logic            pop_o,
  dcc_out_if.source       out_o
);
  import dcc_pkg::*;

  logic [ACC_W-1:0]  last_acc_q, last_acc_d;
  logic [SENT_W-1:0] sent_q, sent_d;
  logic [ACC_W-1:0]  sent_bias_q, sent_bias_d;
  logic              await_q, await_d;

  logic              adv;
  res_t              res_d;
  logic [NUM_W-1:0]  x_d;

  logic              s1_valid_q, s2_valid_q, out_valid_q;
  res_t              s1_res_q, s2_res_q, out_res_q;
  logic [NUM_W-1:0]  s1_x_q, s2_x_q;
  logic [PROD_W-1:0] s2_prod_q, prod_d;
  logic [SENT_W-1:0] out_ack_q;

  logic [QUOT_W-1:0] quot;
  logic [NUM_W-1:0]  qm, rem_raw, rem;

  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && !empty_i;

  always_comb begin
    last_acc_d  = last_acc_q;
    sent_d      = sent_q;
    sent_bias_d = sent_bias_q;
    await_d     = await_q;
    res_d       = '0;
    x_d         = '0;
    if (head_i.is_send) begin
      if (sent_q == SENT_W'(NUM_MOD - 1)) begin
        sent_d      = '0;
        sent_bias_d = ACC_W'(DIGIT_BIAS);
      end else begin
        sent_d      = SENT_W'(sent_q + 1'b1);
        sent_bias_d = ACC_W'(sent_bias_q + 1'b1);
      end
      await_d           = 1'b1;
      res_d.sent_number = sent_d;
      res_d.is_send     = 1'b1;
    end else begin
      priority if (!head_i.port_ok) begin
        res_d.verdict = VERDICT_WRONGPORT;
      end else if (head_i.bad) begin
        res_d.verdict = VERDICT_BAD;
      end else begin
        unique case (head_i.ptype)
          PKT_P: res_d.verdict = VERDICT_NORMAL;
          PKT_S: res_d.verdict = VERDICT_SEARCH;
          PKT_C: begin
            if (head_i.acc < last_acc_q) begin
              res_d.verdict = VERDICT_OLD;
            end else begin
              res_d.verdict  = (head_i.acc == last_acc_q) ? VERDICT_REPEAT : VERDICT_NEW;
              last_acc_d     = head_i.acc;
              res_d.send_ack = 1'b1;
              x_d            = NUM_W'(head_i.acc - ACC_W'(DIGIT_BIAS));
            end
          end
          PKT_R: begin
            res_d.verdict = VERDICT_REPLY;
            if (await_q && head_i.acc == sent_bias_q) begin
              await_d = 1'b0;
            end
          end
          default: res_d.verdict = VERDICT_BAD;
        endcase
      end
      res_d.deliver = head_i.long_pkt && res_d.verdict != VERDICT_BAD &&
                      res_d.verdict != VERDICT_WRONGPORT && res_d.verdict != VERDICT_REPEAT;
    end
    res_d.waiting = await_d;
  end

  assign prod_d  = s1_x_q * RECIP_W'(RECIP);
  assign quot    = s2_prod_q[RECIP_SHIFT +: QUOT_W];
  assign qm      = NUM_W'(quot) * NUM_W'(NUM_MOD);
  assign rem_raw = s2_x_q - qm;
  assign rem     = (rem_raw >= NUM_W'(NUM_MOD)) ? NUM_W'(rem_raw - NUM_W'(NUM_MOD)) : rem_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_acc_q  <= ACC_W'(DIGIT_BIAS);
      sent_q      <= '0;
      sent_bias_q <= ACC_W'(DIGIT_BIAS);
      await_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !empty_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      if (!empty_i) begin
        last_acc_q  <= last_acc_d;
        sent_q      <= sent_d;
        sent_bias_q <= sent_bias_d;
        await_q     <= await_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_res_q  <= res_d;
      s1_x_q    <= x_d;
      s2_res_q  <= s1_res_q;
      s2_x_q    <= s1_x_q;
      s2_prod_q <= prod_d;
      out_res_q <= s2_res_q;
      out_ack_q <= SENT_W'(rem);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.verdict         = out_res_q.verdict;
  assign out_o.deliver_payload = out_res_q.deliver;
  assign out_o.send_ack        = out_res_q.send_ack;
  assign out_o.ack_number      = out_ack_q;
  assign out_o.waiting_confirm = out_res_q.waiting;
  assign out_o.sent_number     = out_res_q.sent_number;
  assign out_o.is_send_result  = out_res_q.is_send;

  a_ack_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.send_ack |->
      (out_o.verdict == VERDICT_NEW || out_o.verdict == VERDICT_REPEAT))
    else $error("Acknowledgement requested for a verdict other than a new or repeated confirm.");

  a_send_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.is_send_result |->
      (out_o.waiting_confirm && out_o.verdict == VERDICT_BAD && !out_o.send_ack))
    else $error("Send result without the waiting flag or with packet fields set.");

  a_ack_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.ack_number < SENT_W'(NUM_MOD) && out_o.sent_number < SENT_W'(NUM_MOD)))
    else $error("Numbers on the output are not reduced modulo one million.");

  a_deliver_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.deliver_payload |->
      (out_o.verdict != VERDICT_BAD && out_o.verdict != VERDICT_WRONGPORT &&
       out_o.verdict != VERDICT_REPEAT))
    else $error("Payload delivered for a bad, foreign or repeated packet.");

endmodule

[hdl/datagram_confirm_header_checker_unit.sv]
// The front end classifies packets and writes each accepted last byte or send event to a four-entry
// queue, which decouples it from the back end; the result then passes the back end's decision stage,
// reciprocal multiply stage and output register, which hold while the output is stalled. One input
// item per cycle is taken while the queue is not full; a byte that ends no packet produces no result.
// Reset is asynchronous and active low; it clears the flags, the send count and the partner port.
module datagram_confirm_header_checker_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dcc_pkg::PORT_W-1:0] cfg_wdata_i,
  dcc_in_if.sink                     in_i,
  dcc_out_if.source                  out_o
);
  import dcc_pkg::*;

  logic   push, pop, full, empty;
  entry_t entry, head;

  dcc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry)
  );

  dcc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  dcc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[bench/dcc_bench_pkg.sv]
// Shared constants for the datagram confirm header checker bench.
// Holds request codes and the packet header bytes; no dependencies.
package dcc_bench_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic [47:0] HEADER_MAGIC = 48'h57_69_64_61_70_5F;
  localparam logic [7:0]  CHAR_ZERO    = 8'h30;

endpackage

[bench/dcc_verdict_monitor.sv]
// Watches the request and result channels of the confirm header checker,
// predicts each verdict and compares it with the block's output.
// Depends on dcc_pkg, dcc_bench_pkg, dcc_in_if and dcc_out_if.
module dcc_verdict_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dcc_pkg::PORT_W-1:0] cfg_wdata_i,
  dcc_in_if                          req_i,
  dcc_out_if                         res_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dcc_pkg::*;
  import dcc_bench_pkg::*;

  typedef struct packed {
    logic [2:0]        verdict;
    logic              deliver;
    logic              send_ack;
    logic [SENT_W-1:0] ack_number;
    logic              waiting;
    logic [SENT_W-1:0] sent_number;
    logic              is_send;
  } verdict_item_t;

  logic [PORT_W-1:0] partner_port;
  int unsigned       rx_count;
  int unsigned       digit_sum;
  logic              header_bad;
  logic [7:0]        type_char;
  logic [7:0]        tail_char;
  int signed         last_confirm;
  logic [SENT_W-1:0] last_sent;
  logic              awaiting;
  verdict_item_t     expected_verdicts[$];

  function automatic string describe(verdict_item_t v);
    return $sformatf("verdict=%0d deliver=%0b ack=%0b ack_number=%0d waiting=%0b sent=%0d send=%0b",
                     v.verdict, v.deliver, v.send_ack, v.ack_number, v.waiting,
                     v.sent_number, v.is_send);
  endfunction

  function automatic void flag_failure(string note);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("%0t ns: %s", $time, note);
    end
  endfunction

  function automatic void classify_request(input logic op, input logic [7:0] b,
                                           input logic is_last, input logic [PORT_W-1:0] port);
    verdict_item_t r;
    int signed     num;
    r = '0;
    if (op == OP_SEND) begin
      last_sent = SENT_W'((last_sent + 1) % NUM_MOD);
      awaiting = 1'b1;
      r.waiting = 1'b1;
      r.sent_number = last_sent;
      r.is_send = 1'b1;
      expected_verdicts.push_back(r);
      return;
    end
    if (rx_count < CAPACITY) begin
      if (rx_count < TYPE_POS && b != HEADER_MAGIC[47 - 8*rx_count -: 8]) begin
        header_bad = 1'b1;
      end
      if (rx_count == TYPE_POS) begin
        type_char = b;
      end
      if (rx_count >= DIGIT_FIRST && rx_count <= DIGIT_LAST) begin
        digit_sum += 32'(b) * (10 ** (DIGIT_LAST - rx_count));
      end
      tail_char = b;
      rx_count++;
    end
    if (!is_last) begin
      return;
    end
    num = int'(digit_sum) - int'(DIGIT_BIAS);
    if (port != partner_port) begin
      r.verdict = VERDICT_WRONGPORT;
    end else if (tail_char != 8'h00 || header_bad || rx_count < MIN_LEN) begin
      r.verdict = VERDICT_BAD;
    end else if (type_char == CHAR_P) begin
      r.verdict = VERDICT_NORMAL;
    end else if (type_char == CHAR_S) begin
      r.verdict = VERDICT_SEARCH;
    end else if (type_char == CHAR_C) begin
      if (num < last_confirm) begin
        r.verdict = VERDICT_OLD;
      end else begin
        r.verdict = (num == last_confirm) ? VERDICT_REPEAT : VERDICT_NEW;
        last_confirm = num;
        r.send_ack = 1'b1;
        r.ack_number = SENT_W'(last_confirm % int'(NUM_MOD));
      end
    end else if (type_char == CHAR_R) begin
      r.verdict = VERDICT_REPLY;
      if (awaiting && num == int'(last_sent)) begin
        awaiting = 1'b0;
      end
    end else begin
      r.verdict = VERDICT_BAD;
    end
    r.deliver = r.verdict >= VERDICT_NORMAL && r.verdict != VERDICT_REPEAT &&
                rx_count > DELIVER_LEN;
    r.waiting = awaiting;
    rx_count = 0;
    digit_sum = 0;
    header_bad = 1'b0;
    type_char = 8'h00;
    tail_char = 8'h00;
    expected_verdicts.push_back(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_item_t seen;
    verdict_item_t want;
    if (!rst_ni) begin
      partner_port = '0;
      rx_count = 0;
      digit_sum = 0;
      header_bad = 1'b0;
      type_char = 8'h00;
      tail_char = 8'h00;
      last_confirm = 0;
      last_sent = '0;
      awaiting = 1'b0;
      expected_verdicts.delete();
      fail_count_o = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        seen = {res_i.verdict, res_i.deliver_payload, res_i.send_ack, res_i.ack_number,
                res_i.waiting_confirm, res_i.sent_number, res_i.is_send_result};
        if (expected_verdicts.size() == 0) begin
          flag_failure({"unexpected result ", describe(seen)});
        end else begin
          want = expected_verdicts.pop_front();
          if (seen !== want) begin
            flag_failure({"mismatch: expected ", describe(want), " got ", describe(seen)});
          end
        end
      end
      if (cfg_we_i) begin
        partner_port = cfg_wdata_i;
      end
      if (req_i.valid && req_i.ready) begin
        classify_request(req_i.op, req_i.byte_value, req_i.last_byte, req_i.source_port);
      end
    end
    pending_o = expected_verdicts.size();
  end

endmodule

[bench/tb_datagram_confirm_header_checker_unit.sv]
// Top of the confirm header checker bench: clock, reset, request stimulus and verdict.
// Drives directed and random packets under several idle and stall mixes.
// Depends on dcc_pkg, dcc_bench_pkg, the channel interfaces and dcc_verdict_monitor.
module tb_datagram_confirm_header_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dcc_pkg::*;
  import dcc_bench_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 500000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned RANDOM_REQUESTS = 1250;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [PORT_W-1:0] cfg_wdata;
  logic [PORT_W-1:0] partner;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       cycle_count;
  int unsigned       random_sent;
  int unsigned       confirm_guess;
  int unsigned       sent_guess;
  logic [7:0]        pkt[$];

  dcc_in_if  req_ch ();
  dcc_out_if res_ch ();

  datagram_confirm_header_checker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_ch),
    .out_o       (res_ch)
  );

  dcc_verdict_monitor verdict_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_request(input logic op, input logic [7:0] b, input logic is_last,
                              input logic [PORT_W-1:0] port);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.byte_value  <= b;
    req_ch.last_byte   <= is_last;
    req_ch.source_port <= port;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    random_sent++;
  endtask

  task automatic send_event();
    sent_guess++;
    push_request(OP_SEND, 8'($urandom), 1'($urandom), PORT_W'($urandom));
  endtask

  task automatic send_packet(input logic [PORT_W-1:0] port, input int insert_at);
    for (int i = 0; i < pkt.size(); i++) begin
      if (i == insert_at) begin
        send_event();
      end
      push_request(OP_BYTE, pkt[i], i == pkt.size() - 1,
                   (i == pkt.size() - 1) ? port : PORT_W'($urandom));
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_partner(input logic [PORT_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    partner = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic build_frame(input logic [7:0] t, input int unsigned n, input int unsigned extra);
    pkt.delete();
    for (int k = 0; k < TYPE_POS; k++) pkt.push_back(HEADER_MAGIC[47 - 8*k -: 8]);
    pkt.push_back(t);
    pkt.push_back(8'($urandom));
    for (int k = 0; k <= DIGIT_LAST - DIGIT_FIRST; k++) begin
      pkt.push_back(8'(CHAR_ZERO + (n / (10 ** (DIGIT_LAST - DIGIT_FIRST - k))) % 10));
    end
    repeat (extra) pkt.push_back(8'($urandom));
    pkt.push_back(8'h00);
  endtask

  task automatic build_oversize(input logic [7:0] stored_tail, input logic [7:0] true_tail);
    build_frame(CHAR_P, 0, 0);
    void'(pkt.pop_back());
    while (pkt.size() < CAPACITY - 1) pkt.push_back(8'($urandom));
    pkt.push_back(stored_tail);
    repeat (4) pkt.push_back(8'hA5);
    pkt.push_back(true_tail);
  endtask

  task automatic random_packet();
    logic [7:0]        t;
    logic [PORT_W-1:0] port;
    int unsigned       n;
    int unsigned       cut;
    int                insert_at;
    bit                raw_digits;
    bit                clean;
    if ($urandom_range(99) < 10) begin
      send_event();
      return;
    end
    raw_digits = 1'b0;
    clean = 1'b1;
    case ($urandom_range(3))
      0:       t = CHAR_P;
      1:       t = CHAR_S;
      2:       t = CHAR_C;
      default: t = CHAR_R;
    endcase
    n = $urandom_range(NUM_MOD - 1);
    if (t == CHAR_C) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          n = confirm_guess + $urandom_range(20000, 1);
          if (n >= NUM_MOD) n = NUM_MOD - 1;
        end
        4, 5: n = confirm_guess;
        6, 7: n = (confirm_guess > 0) ? $urandom_range(confirm_guess - 1) : 0;
        8: ;
        default: raw_digits = 1'b1;
      endcase
    end else if (t == CHAR_R && $urandom_range(9) < 6) begin
      n = sent_guess % NUM_MOD;
    end
    build_frame(t, n, $urandom_range(12));
    if (raw_digits) begin
      for (int k = DIGIT_FIRST; k <= DIGIT_LAST; k++) pkt[k] = 8'($urandom_range(57));
    end
    port = ($urandom_range(9) == 0) ? PORT_W'($urandom) : partner;
    cut = $urandom_range(99);
    if (cut < 8) begin
      pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
      clean = 1'b0;
    end else if (cut < 16) begin
      cut = $urandom_range(pkt.size(), 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
      clean = 1'b0;
    end else if (cut < 24) begin
      pkt.delete();
      repeat ($urandom_range(20, 1)) pkt.push_back(8'($urandom));
      if ($urandom_range(1) == 1) pkt[pkt.size() - 1] = 8'h00;
      clean = 1'b0;
    end
    if (clean && !raw_digits && t == CHAR_C && port == partner && n > confirm_guess) begin
      confirm_guess = n;
    end
    insert_at = ($urandom_range(24) == 0) ? int'($urandom_range(pkt.size() - 1)) : -1;
    send_packet(port, insert_at);
  endtask

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_BYTE;
    req_ch.byte_value  = 8'h00;
    req_ch.last_byte   = 1'b0;
    req_ch.source_port = '0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    partner            = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    confirm_guess      = 0;
    sent_guess         = 0;
    random_sent        = 0;
    rst_ni             = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    pkt.delete();
    pkt.push_back(8'h00);
    send_packet(16'h0000, -1);
    build_frame(CHAR_P, 0, 2);
    send_packet(16'h0000, -1);
    write_partner(16'hFFFF);
    send_event();
    build_frame(CHAR_S, NUM_MOD - 1, 1);
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_C, 123, 2);
    send_packet(16'hFFFF, -1);
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_C, 100, 0);
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_C, 0, 0);
    while (pkt.size() > TYPE_POS + 1) void'(pkt.pop_back());
    pkt.push_back(8'h00);
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_R, 1, 3);
    send_packet(16'hFFFF, -1);
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_P, 0, 0);
    send_packet(16'h0000, -1);
    build_frame(8'hFF, 0, 0);
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_P, 0, 2);
    pkt[0] = ~pkt[0];
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_P, 0, 2);
    pkt[pkt.size() - 1] = 8'hFF;
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_P, 0, 0);
    while (pkt.size() > 4) void'(pkt.pop_back());
    pkt.push_back(8'h00);
    send_packet(16'hFFFF, -1);
    build_frame(CHAR_S, 42, 4);
    send_packet(16'hFFFF, 5);
    build_oversize(8'h00, 8'h5A);
    send_packet(16'hFFFF, -1);
    confirm_guess = 123;

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          write_partner(PORT_W'($urandom));
        end
        1: begin
          idle_pct = 69;
          stall_pct = 0;
          write_partner(16'h0000);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 69;
          write_partner(PORT_W'($urandom));
        end
        default: begin
          idle_pct = 14;
          stall_pct = 14;
          write_partner(16'hFFFF);
        end
      endcase
      random_sent = 0;
      while (random_sent < RANDOM_REQUESTS / 4) begin
        random_packet();
        if ($urandom_range(29) == 0) drain();
      end
    end

    build_frame(CHAR_C, 0, 2);
    for (int k = DIGIT_FIRST; k <= DIGIT_LAST; k++) pkt[k] = 8'hFF;
    send_packet(16'hFFFF, -1);
    send_packet(16'hFFFF, -1);

    drain();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
